// File: hdl/tssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssd_pkg
// Shared types, constants and helpers for the touch sample and swipe detector.
// ----------------------------------------------------------------------------
package tssd_pkg;

    localparam int BYTE_W   = 8;
    localparam int READ_W   = 12;
    localparam int TIME_W   = 32;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 6;
    localparam int LEVEL_W  = 12;
    localparam int DIR_W    = 3;
    localparam int COUNT_W  = 8;
    localparam int WRAP_W   = 16;
    localparam int PRESS_W  = 15;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int GMS_W       = 8;
    localparam int SMD_W       = 7;

    localparam int DIVD_W             = 24;
    localparam int DIVS_W             = 12;
    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES         = DIVD_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

    localparam int ROW_PROD_W = 18;
    localparam int COL_PROD_W = 19;

    localparam logic [CFG_INDEX_W-1:0] CFG_GESTURE_MIN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWIPE_MIN   = 1'b1;

    localparam logic [GMS_W-1:0] GMS_RESET = 8'd25;
    localparam logic [SMD_W-1:0] SMD_RESET = 7'd5;

    localparam logic [BYTE_W-1:0]  IDLE_Z2_HIGH = 8'd127;
    localparam logic [WRAP_W-1:0]  PRESS_FULL   = 16'd4096;
    localparam logic [READ_W-1:0]  ROW_BASE     = 12'd400;
    localparam logic [READ_W-1:0]  COL_BASE     = 12'd200;
    localparam logic [ROW_PROD_W-1:0] ROW_GAIN  = 18'd63;
    localparam logic [COL_PROD_W-1:0] COL_GAIN  = 19'd127;
    localparam logic [DIVS_W-1:0]  ROW_SPAN     = 12'd3200;
    localparam logic [DIVS_W-1:0]  COL_SPAN     = 12'd3600;
    localparam logic [DIVS_W-1:0]  LEVEL_STEP   = 12'd10;
    localparam logic [PRESS_W-1:0] LEVEL_BASE   = 15'd1200;
    localparam logic [ROW_W-1:0]   ROW_MAX      = 6'd63;
    localparam logic [COL_W-1:0]   COL_MAX      = 7'd127;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'd255;

    localparam logic [DIR_W-1:0] DIR_NONE        = 3'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT_RIGHT  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT_LEFT  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_TOP_BOTTOM  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_BOTTOM_TOP  = 3'd4;

    typedef enum logic [1:0] {
        DIV_PRESS,
        DIV_ROW,
        DIV_COL,
        DIV_LEVEL
    } div_sel_t;

    typedef struct packed {
        logic [BYTE_W-1:0] z1_high_byte;
        logic [BYTE_W-1:0] z1_low_byte;
        logic [BYTE_W-1:0] z2_high_byte;
        logic [BYTE_W-1:0] z2_low_byte;
        logic [BYTE_W-1:0] x_high_byte;
        logic [BYTE_W-1:0] x_low_byte;
        logic [BYTE_W-1:0] y_high_byte;
        logic [BYTE_W-1:0] y_low_byte;
        logic [TIME_W-1:0] now_ms;
    } frame_t;

    typedef struct packed {
        logic               touch_accepted;
        logic [COL_W-1:0]   touch_x;
        logic [ROW_W-1:0]   touch_y;
        logic [LEVEL_W-1:0] touch_pressure;
        logic [DIR_W-1:0]   gesture_direction;
        logic [COL_W-1:0]   gesture_start_x;
        logic [ROW_W-1:0]   gesture_start_y;
        logic [COL_W-1:0]   gesture_end_x;
        logic [ROW_W-1:0]   gesture_end_y;
        logic [LEVEL_W-1:0] gesture_peak_pressure;
        logic [TIME_W-1:0]  gesture_duration_ms;
        logic               led_on;
    } result_t;

    typedef struct packed {
        logic     load_frame;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_press;
        logic     cap_row;
        logic     cap_col;
        logic     cap_level;
        logic     commit;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic force_zero;
        logic pressed;
        logic prev_pressed;
        logic out_free;
    } sts_t;

    function automatic logic [READ_W-1:0] unpack12(input logic [BYTE_W-1:0] hi,
                                                   input logic [BYTE_W-1:0] lo);
        unpack12 = {hi[6:0], lo[7:3]};
    endfunction

endpackage

// File: hdl/tssd_frame_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssd_frame_if
// Input channel: one converter frame and its time stamp per item.
// ----------------------------------------------------------------------------
interface tssd_frame_if;
    logic                        valid;
    logic                        ready;
    logic [tssd_pkg::BYTE_W-1:0] z1_high_byte;
    logic [tssd_pkg::BYTE_W-1:0] z1_low_byte;
    logic [tssd_pkg::BYTE_W-1:0] z2_high_byte;
    logic [tssd_pkg::BYTE_W-1:0] z2_low_byte;
    logic [tssd_pkg::BYTE_W-1:0] x_high_byte;
    logic [tssd_pkg::BYTE_W-1:0] x_low_byte;
    logic [tssd_pkg::BYTE_W-1:0] y_high_byte;
    logic [tssd_pkg::BYTE_W-1:0] y_low_byte;
    logic [tssd_pkg::TIME_W-1:0] now_ms;

    modport source (
        output valid, z1_high_byte, z1_low_byte, z2_high_byte, z2_low_byte,
               x_high_byte, x_low_byte, y_high_byte, y_low_byte, now_ms,
        input  ready
    );

    modport sink (
        input  valid, z1_high_byte, z1_low_byte, z2_high_byte, z2_low_byte,
               x_high_byte, x_low_byte, y_high_byte, y_low_byte, now_ms,
        output ready
    );
endinterface

// File: hdl/tssd_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssd_result_if
// Output channel: touch and gesture report, one item per frame.
// ----------------------------------------------------------------------------
interface tssd_result_if;
    logic                         valid;
    logic                         ready;
    logic                         touch_accepted;
    logic [tssd_pkg::COL_W-1:0]   touch_x;
    logic [tssd_pkg::ROW_W-1:0]   touch_y;
    logic [tssd_pkg::LEVEL_W-1:0] touch_pressure;
    logic [tssd_pkg::DIR_W-1:0]   gesture_direction;
    logic [tssd_pkg::COL_W-1:0]   gesture_start_x;
    logic [tssd_pkg::ROW_W-1:0]   gesture_start_y;
    logic [tssd_pkg::COL_W-1:0]   gesture_end_x;
    logic [tssd_pkg::ROW_W-1:0]   gesture_end_y;
    logic [tssd_pkg::LEVEL_W-1:0] gesture_peak_pressure;
    logic [tssd_pkg::TIME_W-1:0]  gesture_duration_ms;
    logic                         led_on;

    modport source (
        output valid, touch_accepted, touch_x, touch_y, touch_pressure,
               gesture_direction, gesture_start_x, gesture_start_y,
               gesture_end_x, gesture_end_y, gesture_peak_pressure,
               gesture_duration_ms, led_on,
        input  ready
    );

    modport sink (
        input  valid, touch_accepted, touch_x, touch_y, touch_pressure,
               gesture_direction, gesture_start_x, gesture_start_y,
               gesture_end_x, gesture_end_y, gesture_peak_pressure,
               gesture_duration_ms, led_on,
        output ready
    );
endinterface

// File: hdl/tssd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssd_datapath
// Frame registers, shared radix-16 divider, touch and gesture state, output
// register and configuration registers.
// ----------------------------------------------------------------------------
module tssd_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tssd_pkg::cmd_t                       cmd,
    output tssd_pkg::sts_t                       sts,
    input  tssd_pkg::frame_t                     frame_data,
    output tssd_pkg::result_t                    result_data,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    input  logic                                 cfg_we,
    input  logic [tssd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tssd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // configuration
    logic [tssd_pkg::GMS_W-1:0] gms_reg;
    logic [tssd_pkg::SMD_W-1:0] smd_reg;

    // frame
    logic [tssd_pkg::READ_W-1:0] z1_reg, z2_reg, x_reg, y_reg;
    logic [tssd_pkg::TIME_W-1:0] now_reg;
    logic                        force_zero_reg;
    logic [tssd_pkg::READ_W-1:0] z1_in;
    logic                        idle_in;

    // divider
    logic [tssd_pkg::DIVD_W-1:0]    quo_reg, quo_next;
    logic [tssd_pkg::DIVS_W-1:0]    rem_reg, rem_next;
    logic [tssd_pkg::DIVS_W-1:0]    divisor_reg, divisor_sel;
    logic [tssd_pkg::DIVD_W-1:0]    dividend_sel;
    logic [tssd_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic                           div_busy_reg;
    logic [tssd_pkg::DIVS_W:0]      trial;

    // operands
    logic [tssd_pkg::DIVD_W-1:0]     press_prod;
    logic [tssd_pkg::READ_W-1:0]     row_off, col_off;
    logic [tssd_pkg::ROW_PROD_W-1:0] row_prod;
    logic [tssd_pkg::COL_PROD_W-1:0] col_prod;
    logic [tssd_pkg::PRESS_W-1:0]    level_off;

    // per-frame values
    logic [tssd_pkg::PRESS_W-1:0] p_reg;
    logic [tssd_pkg::WRAP_W-1:0]  p_wrap;
    logic [tssd_pkg::ROW_W-1:0]   ty_reg;
    logic [tssd_pkg::COL_W-1:0]   tx_reg;
    logic [tssd_pkg::LEVEL_W-1:0] tp_reg;

    // touch and gesture state
    logic                         prev_reg, prev_next;
    logic                         ind_reg, ind_next;
    logic [tssd_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic [tssd_pkg::COL_W-1:0]   run_sx_reg, run_sx_next, run_ex_reg, run_ex_next;
    logic [tssd_pkg::ROW_W-1:0]   run_sy_reg, run_sy_next, run_ey_reg, run_ey_next;
    logic [tssd_pkg::LEVEL_W-1:0] run_peak_reg, run_peak_next;
    logic [tssd_pkg::TIME_W-1:0]  run_t0_reg, run_t0_next;
    logic [tssd_pkg::COL_W-1:0]   held_x_reg, held_x_next;
    logic [tssd_pkg::ROW_W-1:0]   held_y_reg, held_y_next;
    logic [tssd_pkg::LEVEL_W-1:0] held_p_reg, held_p_next;
    logic [tssd_pkg::COL_W-1:0]   rep_sx_reg, rep_sx_next, rep_ex_reg, rep_ex_next;
    logic [tssd_pkg::ROW_W-1:0]   rep_sy_reg, rep_sy_next, rep_ey_reg, rep_ey_next;
    logic [tssd_pkg::LEVEL_W-1:0] rep_peak_reg, rep_peak_next;
    logic [tssd_pkg::TIME_W-1:0]  rep_dur_reg, rep_dur_next;
    logic [tssd_pkg::DIR_W-1:0]   dir_next;
    logic                         accepted_next;

    // classification
    logic [tssd_pkg::COL_W-1:0] dx;
    logic [tssd_pkg::ROW_W-1:0] dy;
    logic [tssd_pkg::DIR_W-1:0] sx, sy;
    logic                       report;

    tssd_pkg::result_t result_reg;
    logic              out_valid_reg;

    assign z1_in   = tssd_pkg::unpack12(frame_data.z1_high_byte, frame_data.z1_low_byte);
    assign idle_in = (frame_data.z1_high_byte == '0) &&
                     (frame_data.z2_high_byte == tssd_pkg::IDLE_Z2_HIGH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gms_reg <= tssd_pkg::GMS_RESET;
            smd_reg <= tssd_pkg::SMD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tssd_pkg::CFG_GESTURE_MIN: gms_reg <= cfg_data[tssd_pkg::GMS_W-1:0];
                tssd_pkg::CFG_SWIPE_MIN:   smd_reg <= cfg_data[tssd_pkg::SMD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_frame)
        begin
            z1_reg         <= z1_in;
            z2_reg         <= tssd_pkg::unpack12(frame_data.z2_high_byte,
                                                 frame_data.z2_low_byte);
            x_reg          <= tssd_pkg::unpack12(frame_data.x_high_byte,
                                                 frame_data.x_low_byte);
            y_reg          <= tssd_pkg::unpack12(frame_data.y_high_byte,
                                                 frame_data.y_low_byte);
            now_reg        <= frame_data.now_ms;
            force_zero_reg <= (z1_in == '0) || idle_in;
        end
    end

    // divider operands
    always_comb
    begin
        press_prod = tssd_pkg::DIVD_W'(x_reg) * tssd_pkg::DIVD_W'(z2_reg);
        row_off    = y_reg - tssd_pkg::ROW_BASE;
        col_off    = x_reg - tssd_pkg::COL_BASE;
        row_prod   = tssd_pkg::ROW_PROD_W'(row_off) * tssd_pkg::ROW_GAIN;
        col_prod   = tssd_pkg::COL_PROD_W'(col_off) * tssd_pkg::COL_GAIN;
        level_off  = p_reg - tssd_pkg::LEVEL_BASE;
        case (cmd.div_sel)
            tssd_pkg::DIV_PRESS:
            begin
                dividend_sel = press_prod;
                divisor_sel  = z1_reg;
            end
            tssd_pkg::DIV_ROW:
            begin
                dividend_sel = (y_reg < tssd_pkg::ROW_BASE) ? '0 :
                               tssd_pkg::DIVD_W'(row_prod);
                divisor_sel  = tssd_pkg::ROW_SPAN;
            end
            tssd_pkg::DIV_COL:
            begin
                dividend_sel = (x_reg < tssd_pkg::COL_BASE) ? '0 :
                               tssd_pkg::DIVD_W'(col_prod);
                divisor_sel  = tssd_pkg::COL_SPAN;
            end
            default:
            begin
                dividend_sel = (p_reg < tssd_pkg::LEVEL_BASE) ? '0 :
                               tssd_pkg::DIVD_W'(level_off);
                divisor_sel  = tssd_pkg::LEVEL_STEP;
            end
        endcase
    end

    // four restoring steps per cycle
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < tssd_pkg::DIV_BITS_PER_CYCLE; i++)
        begin
            trial    = {rem_next, quo_next[tssd_pkg::DIVD_W-1]};
            quo_next = {quo_next[tssd_pkg::DIVD_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial       = trial - {1'b0, divisor_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[tssd_pkg::DIVS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (div_cnt_reg == tssd_pkg::DIV_CNT_W'(tssd_pkg::DIV_CYCLES - 1))
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg     <= dividend_sel;
            rem_reg     <= '0;
            divisor_reg <= divisor_sel;
        end
        else if (div_busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // capture per-frame values
    assign p_wrap = tssd_pkg::PRESS_FULL - quo_reg[tssd_pkg::WRAP_W-1:0] +
                    tssd_pkg::WRAP_W'(x_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.cap_press)
        begin
            if (force_zero_reg)
            begin
                p_reg <= '0;
            end
            else if (p_wrap[tssd_pkg::WRAP_W-1])
            begin
                p_reg <= tssd_pkg::PRESS_W'(1);
            end
            else
            begin
                p_reg <= p_wrap[tssd_pkg::PRESS_W-1:0];
            end
        end
        if (cmd.cap_row)
        begin
            ty_reg <= (quo_reg > tssd_pkg::DIVD_W'(tssd_pkg::ROW_MAX)) ? '0 :
                      tssd_pkg::ROW_MAX - quo_reg[tssd_pkg::ROW_W-1:0];
        end
        if (cmd.cap_col)
        begin
            tx_reg <= (quo_reg > tssd_pkg::DIVD_W'(tssd_pkg::COL_MAX)) ?
                      tssd_pkg::COL_MAX : quo_reg[tssd_pkg::COL_W-1:0];
        end
        if (cmd.cap_level)
        begin
            tp_reg <= (p_reg < tssd_pkg::LEVEL_BASE) ? tssd_pkg::LEVEL_W'(1) :
                      quo_reg[tssd_pkg::LEVEL_W-1:0];
        end
    end

    // release classification
    always_comb
    begin
        if (run_sx_reg < run_ex_reg)
        begin
            dx = run_ex_reg - run_sx_reg;
            sx = tssd_pkg::DIR_LEFT_RIGHT;
        end
        else
        begin
            dx = run_sx_reg - run_ex_reg;
            sx = tssd_pkg::DIR_RIGHT_LEFT;
        end
        if (run_sy_reg < run_ey_reg)
        begin
            dy = run_ey_reg - run_sy_reg;
            sy = tssd_pkg::DIR_TOP_BOTTOM;
        end
        else
        begin
            dy = run_sy_reg - run_ey_reg;
            sy = tssd_pkg::DIR_BOTTOM_TOP;
        end
        report = (cnt_reg > gms_reg) &&
                 ((dx > smd_reg) || (tssd_pkg::SMD_W'(dy) > smd_reg));
    end

    // frame commit
    always_comb
    begin
        prev_next     = prev_reg;
        ind_next      = ind_reg;
        cnt_next      = cnt_reg;
        run_sx_next   = run_sx_reg;
        run_sy_next   = run_sy_reg;
        run_ex_next   = run_ex_reg;
        run_ey_next   = run_ey_reg;
        run_peak_next = run_peak_reg;
        run_t0_next   = run_t0_reg;
        held_x_next   = held_x_reg;
        held_y_next   = held_y_reg;
        held_p_next   = held_p_reg;
        rep_sx_next   = rep_sx_reg;
        rep_sy_next   = rep_sy_reg;
        rep_ex_next   = rep_ex_reg;
        rep_ey_next   = rep_ey_reg;
        rep_peak_next = rep_peak_reg;
        rep_dur_next  = rep_dur_reg;
        dir_next      = tssd_pkg::DIR_NONE;
        accepted_next = 1'b0;
        if (p_reg != '0)
        begin
            if (prev_reg)
            begin
                held_x_next   = tx_reg;
                held_y_next   = ty_reg;
                held_p_next   = tp_reg;
                ind_next      = 1'b1;
                accepted_next = 1'b1;
                run_ex_next   = tx_reg;
                run_ey_next   = ty_reg;
                if (cnt_reg == '0)
                begin
                    run_sx_next   = tx_reg;
                    run_sy_next   = ty_reg;
                    run_peak_next = tp_reg;
                    run_t0_next   = now_reg;
                end
                else if (tp_reg > run_peak_reg)
                begin
                    run_peak_next = tp_reg;
                end
                if (cnt_reg != tssd_pkg::COUNT_MAX)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            prev_next = 1'b1;
        end
        else
        begin
            if (cnt_reg != '0)
            begin
                if (report)
                begin
                    dir_next      = ((tssd_pkg::COL_W'(dy)) < dx) ? sx : sy;
                    rep_sx_next   = run_sx_reg;
                    rep_sy_next   = run_sy_reg;
                    rep_ex_next   = run_ex_reg;
                    rep_ey_next   = run_ey_reg;
                    rep_peak_next = run_peak_reg;
                    rep_dur_next  = now_reg - run_t0_reg;
                end
                cnt_next = '0;
            end
            prev_next = 1'b0;
            ind_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= 1'b0;
            ind_reg      <= 1'b0;
            cnt_reg      <= '0;
            run_sx_reg   <= '0;
            run_sy_reg   <= '0;
            run_ex_reg   <= '0;
            run_ey_reg   <= '0;
            run_peak_reg <= '0;
            run_t0_reg   <= '0;
            held_x_reg   <= '0;
            held_y_reg   <= '0;
            held_p_reg   <= '0;
            rep_sx_reg   <= '0;
            rep_sy_reg   <= '0;
            rep_ex_reg   <= '0;
            rep_ey_reg   <= '0;
            rep_peak_reg <= '0;
            rep_dur_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            prev_reg     <= prev_next;
            ind_reg      <= ind_next;
            cnt_reg      <= cnt_next;
            run_sx_reg   <= run_sx_next;
            run_sy_reg   <= run_sy_next;
            run_ex_reg   <= run_ex_next;
            run_ey_reg   <= run_ey_next;
            run_peak_reg <= run_peak_next;
            run_t0_reg   <= run_t0_next;
            held_x_reg   <= held_x_next;
            held_y_reg   <= held_y_next;
            held_p_reg   <= held_p_next;
            rep_sx_reg   <= rep_sx_next;
            rep_sy_reg   <= rep_sy_next;
            rep_ex_reg   <= rep_ex_next;
            rep_ey_reg   <= rep_ey_next;
            rep_peak_reg <= rep_peak_next;
            rep_dur_reg  <= rep_dur_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_reg.touch_accepted        <= accepted_next;
            result_reg.touch_x               <= held_x_next;
            result_reg.touch_y               <= held_y_next;
            result_reg.touch_pressure        <= held_p_next;
            result_reg.gesture_direction     <= dir_next;
            result_reg.gesture_start_x       <= rep_sx_next;
            result_reg.gesture_start_y       <= rep_sy_next;
            result_reg.gesture_end_x         <= rep_ex_next;
            result_reg.gesture_end_y         <= rep_ey_next;
            result_reg.gesture_peak_pressure <= rep_peak_next;
            result_reg.gesture_duration_ms   <= rep_dur_next;
            result_reg.led_on                <= ind_next;
        end
    end

    assign result_data  = result_reg;
    assign result_valid = out_valid_reg;

    assign sts.div_busy     = div_busy_reg;
    assign sts.force_zero   = force_zero_reg;
    assign sts.pressed      = (p_reg != '0);
    assign sts.prev_pressed = prev_reg;
    assign sts.out_free     = !out_valid_reg || result_ready;

    a_led_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
        ind_reg |-> (cnt_reg != '0))
        else $error("indicator active with empty sample count");

    a_count_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> prev_reg)
        else $error("sample count held without a pressed frame");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> (divisor_reg != '0))
        else $error("divider running on a zero divisor");

endmodule

// File: hdl/tssd_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssd_controller
// Frame sequencer: pressure divide unless pressure is forced to zero, then
// scaling divides for an accepted touch, then commit into the output register.
// ----------------------------------------------------------------------------
module tssd_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           frame_valid,
    output logic           frame_ready,
    input  tssd_pkg::sts_t sts,
    output tssd_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_PDIV,
        S_PCAP,
        S_CHECK,
        S_RDIV,
        S_RCAP,
        S_CDIV,
        S_CCAP,
        S_LDIV,
        S_LCAP,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign frame_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.div_sel    = tssd_pkg::DIV_PRESS;
        case (state_reg)
            S_IDLE:
            begin
                if (frame_valid)
                begin
                    cmd.load_frame = 1'b1;
                    state_next     = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (sts.force_zero)
                begin
                    state_next = S_PCAP;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_PDIV;
                end
            end
            S_PDIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_PCAP;
                end
            end
            S_PCAP:
            begin
                cmd.cap_press = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.pressed && sts.prev_pressed)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = tssd_pkg::DIV_ROW;
                    state_next    = S_RDIV;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_RDIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_RCAP;
                end
            end
            S_RCAP:
            begin
                cmd.cap_row   = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = tssd_pkg::DIV_COL;
                state_next    = S_CDIV;
            end
            S_CDIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_CCAP;
                end
            end
            S_CCAP:
            begin
                cmd.cap_col   = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = tssd_pkg::DIV_LEVEL;
                state_next    = S_LDIV;
            end
            S_LDIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_LCAP;
                end
            end
            S_LCAP:
            begin
                cmd.cap_level = 1'b1;
                state_next    = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("commit while output register still full");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider restarted while busy");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_ready) |=> (state_reg == S_LOAD))
        else $error("accepted item not followed by load");

endmodule

// File: hdl/touch_sample_and_swipe_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_and_swipe_detector
// Touch frame pressure, position scaling and swipe classification.
//
// Channel   Dir  Handshake      Contents
// frame     in   valid/ready    eight converter bytes, now_ms
// result    out  valid/ready    touch position, gesture report, led_on
// cfg       in   cfg_we         cfg_index, cfg_data (no read-back)
//
// One item at a time; a shared divider yields four quotient bits per cycle.
// Each frame runs a pressure divide, skipped when pressure is forced to zero,
// and three more divides when the touch position is updated. Reset is
// asynchronous and active low; it clears all touch and gesture state and
// restores the register defaults. A full output register holds the
// sequencer in its commit step until the item is taken.
// ----------------------------------------------------------------------------
module touch_sample_and_swipe_detector (
    input  logic                                 clk,
    input  logic                                 rst_n,
    tssd_frame_if.sink                           frame,
    tssd_result_if.source                        result,
    input  logic                                 cfg_we,
    input  logic [tssd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tssd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    tssd_pkg::cmd_t    cmd;
    tssd_pkg::sts_t    sts;
    tssd_pkg::frame_t  frame_data;
    tssd_pkg::result_t result_data;
    logic              frame_ready;
    logic              result_valid;

    assign frame_data.z1_high_byte = frame.z1_high_byte;
    assign frame_data.z1_low_byte  = frame.z1_low_byte;
    assign frame_data.z2_high_byte = frame.z2_high_byte;
    assign frame_data.z2_low_byte  = frame.z2_low_byte;
    assign frame_data.x_high_byte  = frame.x_high_byte;
    assign frame_data.x_low_byte   = frame.x_low_byte;
    assign frame_data.y_high_byte  = frame.y_high_byte;
    assign frame_data.y_low_byte   = frame.y_low_byte;
    assign frame_data.now_ms       = frame.now_ms;
    assign frame.ready             = frame_ready;

    tssd_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame.valid),
        .frame_ready (frame_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    tssd_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .frame_data   (frame_data),
        .result_data  (result_data),
        .result_valid (result_valid),
        .result_ready (result.ready),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    assign result.valid                 = result_valid;
    assign result.touch_accepted        = result_data.touch_accepted;
    assign result.touch_x               = result_data.touch_x;
    assign result.touch_y               = result_data.touch_y;
    assign result.touch_pressure        = result_data.touch_pressure;
    assign result.gesture_direction     = result_data.gesture_direction;
    assign result.gesture_start_x       = result_data.gesture_start_x;
    assign result.gesture_start_y       = result_data.gesture_start_y;
    assign result.gesture_end_x         = result_data.gesture_end_x;
    assign result.gesture_end_y         = result_data.gesture_end_y;
    assign result.gesture_peak_pressure = result_data.gesture_peak_pressure;
    assign result.gesture_duration_ms   = result_data.gesture_duration_ms;
    assign result.led_on                = result_data.led_on;

endmodule

// File: tb/touch_sample_and_swipe_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_and_swipe_detector_test
// Self-checking bench for the touch sample and swipe detector. Frames are
// driven on the frame channel and every report is compared field by field
// against an in-bench model of pressure, position scaling, pressure banding
// and swipe classification. Directed frames cover forced-zero pressure, the
// negative and wrapped-zero pressure cases, pressure bands and position
// limits; random strokes and noise run under several threshold settings and
// idle patterns, with a long receiver hold-off and sample count saturation.
// ----------------------------------------------------------------------------
module touch_sample_and_swipe_detector_test;
    import tssd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = 40;

    typedef enum int {
        REL_ZERO_Z1,
        REL_IDLE,
        REL_WRAP
    } release_kind_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tssd_frame_if  frame();
    tssd_result_if result();

    touch_sample_and_swipe_detector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    int error_count = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int hold_cycles_left = 0;
    logic [TIME_W-1:0] now_counter = '0;
    result_t pending_reports[$];

    logic [GMS_W-1:0]   min_samples;
    logic [SMD_W-1:0]   min_distance;
    logic               was_pressed;
    logic               led_state;
    logic [COUNT_W-1:0] sample_count;
    logic [COL_W-1:0]   stroke_start_x, stroke_end_x, shown_x, gest_start_x, gest_end_x;
    logic [ROW_W-1:0]   stroke_start_y, stroke_end_y, shown_y, gest_start_y, gest_end_y;
    logic [LEVEL_W-1:0] stroke_peak, shown_level, gest_peak;
    logic [TIME_W-1:0]  stroke_t0, gest_duration;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles_left > 0)
        begin
            hold_cycles_left--;
            result.ready = 1'b0;
        end
        else
        begin
            result.ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (result.valid === 1'b1 && result.ready === 1'b1)
            check_report();
    end

    task automatic predict_report(input frame_t f, output result_t r);
        logic [READ_W-1:0]  z1, z2, xr, yr;
        logic [31:0]        quot, wrapped;
        logic [WRAP_W-1:0]  press;
        logic [COL_W-1:0]   tx, dx;
        logic [ROW_W-1:0]   ty, dy;
        logic [LEVEL_W-1:0] level;
        logic [DIR_W-1:0]   dir, dir_x, dir_y;
        logic               took;
        int unsigned        scaled;
        z1 = {f.z1_high_byte[6:0], f.z1_low_byte[7:3]};
        z2 = {f.z2_high_byte[6:0], f.z2_low_byte[7:3]};
        xr = {f.x_high_byte[6:0], f.x_low_byte[7:3]};
        yr = {f.y_high_byte[6:0], f.y_low_byte[7:3]};
        press = '0;
        took = 1'b0;
        dir = DIR_NONE;
        if (z1 != 0 && !(f.z1_high_byte == 8'd0 && f.z2_high_byte == IDLE_Z2_HIGH))
        begin
            quot = ({20'd0, xr} * {20'd0, z2}) / {20'd0, z1};
            wrapped = 32'd4096 - (quot - {20'd0, xr});
            press = wrapped[15:0];
            if (press[15])
                press = 16'd1;
        end
        if (press != 0)
        begin
            if (was_pressed)
            begin
                scaled = (yr < 400) ? 0 : ((yr - 400) * 63) / 3200;
                if (scaled > 63)
                    scaled = 63;
                ty = 63 - scaled;
                scaled = (xr < 200) ? 0 : ((xr - 200) * 127) / 3600;
                if (scaled > 127)
                    scaled = 127;
                tx = scaled;
                level = (press < 1200) ? 12'd1 : (press - 1200) / 10;
                shown_x = tx;
                shown_y = ty;
                shown_level = level;
                led_state = 1'b1;
                took = 1'b1;
                stroke_end_x = tx;
                stroke_end_y = ty;
                if (sample_count == 0)
                begin
                    stroke_start_x = tx;
                    stroke_start_y = ty;
                    stroke_peak = level;
                    stroke_t0 = f.now_ms;
                end
                else if (level > stroke_peak)
                begin
                    stroke_peak = level;
                end
                if (sample_count != COUNT_MAX)
                    sample_count++;
            end
            was_pressed = 1'b1;
        end
        else
        begin
            if (sample_count != 0 && sample_count > min_samples)
            begin
                if (stroke_start_x < stroke_end_x)
                begin
                    dx = stroke_end_x - stroke_start_x;
                    dir_x = DIR_LEFT_RIGHT;
                end
                else
                begin
                    dx = stroke_start_x - stroke_end_x;
                    dir_x = DIR_RIGHT_LEFT;
                end
                if (stroke_start_y < stroke_end_y)
                begin
                    dy = stroke_end_y - stroke_start_y;
                    dir_y = DIR_TOP_BOTTOM;
                end
                else
                begin
                    dy = stroke_start_y - stroke_end_y;
                    dir_y = DIR_BOTTOM_TOP;
                end
                if (dx > min_distance || dy > min_distance)
                begin
                    dir = (dx > dy) ? dir_x : dir_y;
                    gest_start_x = stroke_start_x;
                    gest_start_y = stroke_start_y;
                    gest_end_x = stroke_end_x;
                    gest_end_y = stroke_end_y;
                    gest_peak = stroke_peak;
                    gest_duration = f.now_ms - stroke_t0;
                end
            end
            sample_count = '0;
            was_pressed = 1'b0;
            led_state = 1'b0;
        end
        r.touch_accepted = took;
        r.touch_x = shown_x;
        r.touch_y = shown_y;
        r.touch_pressure = shown_level;
        r.gesture_direction = dir;
        r.gesture_start_x = gest_start_x;
        r.gesture_start_y = gest_start_y;
        r.gesture_end_x = gest_end_x;
        r.gesture_end_y = gest_end_y;
        r.gesture_peak_pressure = gest_peak;
        r.gesture_duration_ms = gest_duration;
        r.led_on = led_state;
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t mismatch %s expected %0d actual %0d", $time, label, want, got);
            error_count++;
        end
    endtask

    task automatic check_report();
        result_t want;
        if (pending_reports.size() == 0)
        begin
            $display("%0t report with none outstanding", $time);
            error_count++;
        end
        else
        begin
            want = pending_reports.pop_front();
            check_field("touch_accepted", want.touch_accepted, result.touch_accepted);
            check_field("touch_x", want.touch_x, result.touch_x);
            check_field("touch_y", want.touch_y, result.touch_y);
            check_field("touch_pressure", want.touch_pressure, result.touch_pressure);
            check_field("gesture_direction", want.gesture_direction,
                        result.gesture_direction);
            check_field("gesture_start_x", want.gesture_start_x, result.gesture_start_x);
            check_field("gesture_start_y", want.gesture_start_y, result.gesture_start_y);
            check_field("gesture_end_x", want.gesture_end_x, result.gesture_end_x);
            check_field("gesture_end_y", want.gesture_end_y, result.gesture_end_y);
            check_field("gesture_peak_pressure", want.gesture_peak_pressure,
                        result.gesture_peak_pressure);
            check_field("gesture_duration_ms", want.gesture_duration_ms,
                        result.gesture_duration_ms);
            check_field("led_on", want.led_on, result.led_on);
        end
    endtask

    function automatic frame_t make_frame(input logic [READ_W-1:0] z1, z2, xr, yr);
        frame_t      f;
        logic [31:0] spare;
        spare = $urandom();
        f.z1_high_byte = {spare[0], z1[11:5]};
        f.z1_low_byte  = {z1[4:0], spare[3:1]};
        f.z2_high_byte = {spare[4], z2[11:5]};
        f.z2_low_byte  = {z2[4:0], spare[7:5]};
        f.x_high_byte  = {spare[8], xr[11:5]};
        f.x_low_byte   = {xr[4:0], spare[11:9]};
        f.y_high_byte  = {spare[12], yr[11:5]};
        f.y_low_byte   = {yr[4:0], spare[15:13]};
        f.now_ms       = now_counter;
        return f;
    endfunction

    task automatic send_frame(input frame_t f);
        result_t want;
        while ($urandom_range(99) < src_idle_pct)
        begin
            frame.valid = 1'b0;
            @(negedge clk);
        end
        frame.valid = 1'b1;
        frame.z1_high_byte = f.z1_high_byte;
        frame.z1_low_byte = f.z1_low_byte;
        frame.z2_high_byte = f.z2_high_byte;
        frame.z2_low_byte = f.z2_low_byte;
        frame.x_high_byte = f.x_high_byte;
        frame.x_low_byte = f.x_low_byte;
        frame.y_high_byte = f.y_high_byte;
        frame.y_low_byte = f.y_low_byte;
        frame.now_ms = f.now_ms;
        @(posedge clk);
        while (frame.ready !== 1'b1)
            @(posedge clk);
        predict_report(f, want);
        pending_reports.push_back(want);
        now_counter += $urandom_range(40);
        @(negedge clk);
    endtask

    task automatic send_reading(input logic [READ_W-1:0] z1, z2, xr, yr);
        send_frame(make_frame(z1, z2, xr, yr));
    endtask

    task automatic send_release(input release_kind_t kind);
        frame_t f;
        case (kind)
            REL_ZERO_Z1:
                f = make_frame('0, $urandom_range(4095), $urandom_range(4095),
                               $urandom_range(4095));
            REL_IDLE:
            begin
                f = make_frame($urandom_range(31, 1), $urandom_range(4095),
                               $urandom_range(4095), $urandom_range(4095));
                f.z1_high_byte = 8'd0;
                f.z2_high_byte = IDLE_Z2_HIGH;
            end
            default:
                f = make_frame(12'd2, 12'd5, 12'd2731, $urandom_range(4095));
        endcase
        send_frame(f);
    endtask

    task automatic send_stroke(input int len, input int x0, input int y0,
                               input int x1, input int y1);
        int                i;
        int                xv, yv;
        logic [READ_W-1:0] z1, z2;
        for (i = 0; i < len; i++)
        begin
            xv = (len > 1) ? x0 + (x1 - x0) * i / (len - 1) : x0;
            yv = (len > 1) ? y0 + (y1 - y0) * i / (len - 1) : y0;
            z1 = $urandom_range(4095, 1);
            z2 = $urandom_range(1) ? $urandom_range(4095) : $urandom_range(z1);
            send_reading(z1, z2, xv, yv);
        end
        send_release(release_kind_t'($urandom_range(2)));
    endtask

    task automatic quiesce();
        frame.valid = 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_GESTURE_MIN)
            min_samples = data;
        else
            min_distance = data[SMD_W-1:0];
    endtask

    task automatic set_thresholds(input logic [7:0] gms, input logic [7:0] smd);
        quiesce();
        write_reg(CFG_GESTURE_MIN, gms);
        write_reg(CFG_SWIPE_MIN, smd);
    endtask

    task automatic test_special_frames();
        set_thresholds(8'd0, 8'd0);
        now_counter = 32'hFFFF_FFE0;
        send_release(REL_ZERO_Z1);
        send_release(REL_IDLE);
        send_reading(12'd4095, 12'd4095, 12'd0, 12'd0);
        send_reading(12'd2, 12'd5, 12'd2800, 12'd2000);
        send_reading(12'd1, 12'd74, 12'd505, 12'd4095);
        send_reading(12'd1, 12'd2, 12'd2896, 12'd1000);
        send_reading(12'd1, 12'd2, 12'd3000, 12'd3000);
        send_reading(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_release(REL_WRAP);
        send_frame('0);
        send_frame('1);
    endtask

    task automatic test_swipe_directions();
        send_stroke(3, 200, 2000, 4095, 2000);
        send_stroke(3, 4095, 2000, 200, 2000);
        send_stroke(3, 2000, 4095, 2000, 400);
        send_stroke(3, 2000, 400, 2000, 4095);
        send_stroke(3, 200, 400, 484, 908);
    endtask

    task automatic test_random_traffic(input int count);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                if ($urandom_range(1))
                    len = $urandom_range(min_samples + 6, min_samples + 2);
                else
                    len = $urandom_range(min_samples + 1, 1);
                send_stroke(len, $urandom_range(4095), $urandom_range(4095),
                            $urandom_range(4095), $urandom_range(4095));
                sent += len + 1;
            end
            else if (pick < 90)
            begin
                send_frame({$urandom(), $urandom(), $urandom()});
                sent++;
            end
            else
            begin
                send_release(release_kind_t'($urandom_range(2)));
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_cycles_left = 500;
        send_stroke(15, 4095, 4095, 200, 400);
        quiesce();
    endtask

    task automatic test_count_saturation();
        set_thresholds(8'd254, 8'd0);
        send_stroke(258, 200, 400, 4095, 4095);
        set_thresholds(8'd255, 8'd0);
        send_stroke(258, 4095, 4095, 200, 400);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        result.ready = 1'b0;
        frame.valid = 1'b0;
        frame.z1_high_byte = '0;
        frame.z1_low_byte = '0;
        frame.z2_high_byte = '0;
        frame.z2_low_byte = '0;
        frame.x_high_byte = '0;
        frame.x_low_byte = '0;
        frame.y_high_byte = '0;
        frame.y_low_byte = '0;
        frame.now_ms = '0;
        min_samples = GMS_RESET;
        min_distance = SMD_RESET;
        was_pressed = 1'b0;
        led_state = 1'b0;
        sample_count = '0;
        {stroke_start_x, stroke_end_x, shown_x, gest_start_x, gest_end_x} = '0;
        {stroke_start_y, stroke_end_y, shown_y, gest_start_y, gest_end_y} = '0;
        {stroke_peak, shown_level, gest_peak} = '0;
        {stroke_t0, gest_duration} = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        src_idle_pct = 33;
        sink_idle_pct = 62;
        test_random_traffic(40);
        test_special_frames();
        test_swipe_directions();
        test_random_traffic(200);
        set_thresholds(8'd3, 8'd127);
        test_random_traffic(180);

        src_idle_pct = 62;
        sink_idle_pct = 33;
        set_thresholds($urandom_range(8, 1), $urandom_range(255) & 8'h9F);
        test_random_traffic(200);
        test_backpressure();
        set_thresholds(GMS_RESET, SMD_RESET);
        test_random_traffic(200);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_count_saturation();
        set_thresholds($urandom_range(6), $urandom_range(10));
        test_random_traffic(280);

        quiesce();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
